### rtl/mcfe_pkg.sv
package mcfe_pkg;

	localparam logic [7:0] HDR_BYTE0 = 8'hEF;
	localparam logic [7:0] HDR_BYTE1 = 8'hAA;
	localparam int         APB_ADDR_W = 3;
	localparam logic       REG_SCRAMBLE_ENABLE = 1'b0;

	typedef struct packed {
		logic            valid;
		logic            frame_end;
		logic [2:0]      last_idx;
		logic [7:0][7:0] data;
	} mcfe_bundle_t;

	function automatic logic [7:0] scramble_key(input logic [3:0] k);
		logic [7:0] v;
		case (k)
			4'd0:    v = 8'h65;
			4'd1:    v = 8'h66;
			4'd2:    v = 8'h36;
			4'd3:    v = 8'h61;
			4'd4:    v = 8'h30;
			4'd5:    v = 8'h32;
			4'd6:    v = 8'h32;
			4'd7:    v = 8'h39;
			4'd8:    v = 8'h64;
			4'd9:    v = 8'h64;
			4'd10:   v = 8'h34;
			4'd11:   v = 8'h39;
			4'd12:   v = 8'h30;
			4'd13:   v = 8'h39;
			4'd14:   v = 8'h62;
			4'd15:   v = 8'h37;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] body_byte(input logic [7:0] b, input logic [3:0] k,
		input logic scr);
		logic [7:0] v;
		if (scr) begin
			v = ~(b ^ scramble_key(k));
		end else begin
			v = b;
		end
		return v;
	endfunction

endpackage

### rtl/mcfe_if.sv
interface mcfe_in_if;
	logic       valid;
	logic       ready;
	logic       is_header;
	logic [7:0] cmd_code;
	logic [7:0] param_count;
	logic [7:0] param_byte;

	modport source (output valid, output is_header, output cmd_code, output param_count,
		output param_byte, input ready);
	modport sink (input valid, input is_header, input cmd_code, input param_count,
		input param_byte, output ready);
endinterface

interface mcfe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;

	modport source (output valid, output frame_byte, output frame_end, input ready);
	modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

### rtl/module_command_frame_encoder_unit.sv
// Channel   Dir  Payload                                         Handshake
// in_ch     in   is_header, cmd_code, param_count, param_byte    valid/ready
// out_ch    out  frame_byte, frame_end                           valid/ready
// apb       in   scramble_enable at word 0                       psel/penable, pready high
//
// An item is turned into all of its frame bytes in the cycle it is accepted and
// the bytes are held in a result register, then sent one per cycle while
// out_ch.ready is high. A header item gives five to eight frame bytes, a
// parameter item one or two.
// A new item is taken in the cycle the last byte of the previous one is taken.
// Reset clears the frame state, the mode register and the result register.
module module_command_frame_encoder_unit
	import mcfe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	mcfe_in_if.sink               in_ch,
	mcfe_out_if.source            out_ch
);

	logic         scramble_q;
	mcfe_bundle_t bundle;
	mcfe_bundle_t bundle_q;
	logic [2:0]   idx_q;
	logic         busy_q;
	logic         out_fire;
	logic         out_last;
	logic         in_fire;

	assign pready = 1'b1;
	assign prdata = {31'b0, scramble_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scramble_q <= 1'b0;
		end else if (psel && penable && pwrite && pready
			&& (paddr[APB_ADDR_W-1] == REG_SCRAMBLE_ENABLE)) begin
			scramble_q <= pwdata[0];
		end
	end

	assign out_last = (idx_q == bundle_q.last_idx);
	assign out_fire = out_ch.valid && out_ch.ready;
	assign in_ch.ready = !busy_q || (out_ch.ready && out_last);
	assign in_fire = in_ch.valid && in_ch.ready;

	mcfe_builder u_builder (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (in_fire),
		.scr         (scramble_q),
		.is_header   (in_ch.is_header),
		.cmd_code    (in_ch.cmd_code),
		.param_count (in_ch.param_count),
		.param_byte  (in_ch.param_byte),
		.bundle      (bundle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bundle_q <= '0;
			idx_q <= '0;
			busy_q <= 1'b0;
		end else begin
			if (in_fire && bundle.valid) begin
				bundle_q <= bundle;
				idx_q <= '0;
				busy_q <= 1'b1;
			end else if (out_fire) begin
				if (out_last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	assign out_ch.valid = busy_q;
	assign out_ch.frame_byte = bundle_q.data[idx_q];
	assign out_ch.frame_end = bundle_q.frame_end && out_last;

endmodule

### rtl/mcfe_builder.sv
module mcfe_builder
	import mcfe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  logic         scr,
	input  logic         is_header,
	input  logic [7:0]   cmd_code,
	input  logic [7:0]   param_count,
	input  logic [7:0]   param_byte,
	output mcfe_bundle_t bundle
);

	logic [3:0] key_pos_q;
	logic [7:0] xor_q;
	logic [7:0] remaining_q;

	logic [3:0] key_pos_d;
	logic [7:0] xor_d;
	logic [7:0] remaining_d;
	logic [7:0] v0, v1, v2, vp;

	always_comb begin
		v0 = body_byte(cmd_code, 4'd0, scr);
		v1 = body_byte(8'h00, 4'd1, scr);
		v2 = body_byte(param_count, 4'd2, scr);
		vp = body_byte(param_byte, key_pos_q, scr);

		bundle = '0;
		key_pos_d = key_pos_q;
		xor_d = xor_q;
		remaining_d = remaining_q;

		if (is_header) begin
			key_pos_d = 4'd3;
			xor_d = v0 ^ v1 ^ v2;
			remaining_d = param_count;
			bundle.valid = 1'b1;
			bundle.frame_end = (param_count == 8'd0);
			bundle.data[0] = HDR_BYTE0;
			bundle.data[1] = HDR_BYTE1;
			if (scr) begin
				bundle.data[2] = 8'h00;
				bundle.data[3] = param_count + 8'd3;
				bundle.data[4] = v0;
				bundle.data[5] = v1;
				bundle.data[6] = v2;
				bundle.data[7] = v0 ^ v1 ^ v2;
				bundle.last_idx = (param_count == 8'd0) ? 3'd7 : 3'd6;
			end else begin
				bundle.data[2] = v0;
				bundle.data[3] = v1;
				bundle.data[4] = v2;
				bundle.data[5] = v0 ^ v1 ^ v2;
				bundle.last_idx = (param_count == 8'd0) ? 3'd5 : 3'd4;
			end
		end else if (remaining_q != 8'd0) begin
			key_pos_d = key_pos_q + 4'd1;
			xor_d = xor_q ^ vp;
			remaining_d = remaining_q - 8'd1;
			bundle.valid = 1'b1;
			bundle.frame_end = (remaining_q == 8'd1);
			bundle.data[0] = vp;
			bundle.data[1] = xor_q ^ vp;
			bundle.last_idx = (remaining_q == 8'd1) ? 3'd1 : 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pos_q <= '0;
			xor_q <= '0;
			remaining_q <= '0;
		end else if (fire) begin
			key_pos_q <= key_pos_d;
			xor_q <= xor_d;
			remaining_q <= remaining_d;
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mcfe_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 12;
	localparam logic [APB_ADDR_W-1:0] SCRAMBLE_ADDR = APB_ADDR_W'(4 * REG_SCRAMBLE_ENABLE);
	localparam logic [127:0] SCRAMBLE_KEY = "ef6a0229dd4909b7";

	typedef struct packed {
		logic       is_header;
		logic [7:0] cmd;
		logic [7:0] count;
		logic [7:0] pbyte;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] fbyte;
		logic       fend;
	} frame_out_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	mcfe_in_if  in_bus();
	mcfe_out_if out_bus();

	module_command_frame_encoder_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_bus),
		.out_ch  (out_bus)
	);

	frame_out_t exp_bytes[$];
	bit         scr_mode;
	logic [3:0] key_idx;
	logic [7:0] csum;
	logic [7:0] params_left;

	int errors;
	int send_idle_pct;
	int recv_idle_pct;
	int effective_items;
	int header_items;
	int checked_bytes;
	int closed_frames;
	int quiet_cycles;

	always #6 clk = ~clk;

	always @(negedge clk) begin
		out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic void note_error(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("mismatch: %s", msg);
		end
	endfunction

	function automatic void push_byte(input logic [7:0] b, input logic e);
		exp_bytes.push_back('{fbyte: b, fend: e});
	endfunction

	function automatic void push_body(input logic [7:0] b);
		logic [7:0] v;
		v = scr_mode ? ~(b ^ SCRAMBLE_KEY[8*(15-key_idx) +: 8]) : b;
		key_idx = key_idx + 4'd1;
		csum = csum ^ v;
		push_byte(v, 1'b0);
	endfunction

	// Returns 1 when the item has an effect, 0 for a parameter with no frame open.
	function automatic bit predict_frame(input cmd_item_t it);
		if (it.is_header) begin
			key_idx = '0;
			csum = '0;
			params_left = it.count;
			push_byte(HDR_BYTE0, 1'b0);
			push_byte(HDR_BYTE1, 1'b0);
			if (scr_mode) begin
				push_byte(8'h00, 1'b0);
				push_byte(it.count + 8'd3, 1'b0);
			end
			push_body(it.cmd);
			push_body(8'h00);
			push_body(it.count);
			if (params_left == 0) begin
				push_byte(csum, 1'b1);
			end
			return 1'b1;
		end
		if (params_left == 0) begin
			return 1'b0;
		end
		push_body(it.pbyte);
		params_left = params_left - 8'd1;
		if (params_left == 0) begin
			push_byte(csum, 1'b1);
		end
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		frame_out_t want;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			checked_bytes++;
			if (out_bus.frame_end) begin
				closed_frames++;
			end
			if (exp_bytes.size() == 0) begin
				note_error($sformatf("unexpected frame byte %02h end %0b",
					out_bus.frame_byte, out_bus.frame_end));
			end else begin
				want = exp_bytes.pop_front();
				if (out_bus.frame_byte !== want.fbyte) begin
					note_error($sformatf("frame_byte expected %02h actual %02h",
						want.fbyte, out_bus.frame_byte));
				end
				if (out_bus.frame_end !== want.fend) begin
					note_error($sformatf("frame_end expected %0b actual %0b (byte %02h)",
						want.fend, out_bus.frame_end, out_bus.frame_byte));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_item(input cmd_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_bus.valid <= 1'b0;
			@(negedge clk);
		end
		in_bus.valid       <= 1'b1;
		in_bus.is_header   <= it.is_header;
		in_bus.cmd_code    <= it.cmd;
		in_bus.param_count <= it.count;
		in_bus.param_byte  <= it.pbyte;
		@(posedge clk);
		while (!in_bus.ready) begin
			@(posedge clk);
		end
		if (it.is_header) begin
			header_items++;
		end
		if (predict_frame(it)) begin
			effective_items++;
		end
	endtask

	task automatic send_header(input logic [7:0] cmd, input logic [7:0] count);
		send_item('{is_header: 1'b1, cmd: cmd, count: count, pbyte: 8'($urandom)});
	endtask

	task automatic send_param(input logic [7:0] pbyte);
		send_item('{is_header: 1'b0, cmd: 8'($urandom), count: 8'($urandom), pbyte: pbyte});
	endtask

	task automatic drain_frames();
		@(negedge clk);
		in_bus.valid <= 1'b0;
		while (exp_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_scramble(input bit value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= SCRAMBLE_ADDR;
		pwdata  <= {31'b0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		scr_mode = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (prdata !== {31'b0, value}) begin
			note_error($sformatf("scramble_enable readback expected %08h actual %08h",
				{31'b0, value}, prdata));
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_plain_frames();
		set_scramble(1'b0);
		send_param(8'hFF);
		send_header(8'h00, 8'd0);
		send_header(8'hFF, 8'd2);
		send_param(8'h00);
		send_param(8'hFF);
		send_header(8'h5A, 8'd1);
		send_header(8'hA5, 8'd0);
		send_param(8'h33);
		drain_frames();
	endtask

	task automatic test_scrambled_frames();
		set_scramble(1'b1);
		send_header(8'h00, 8'd0);
		send_header(8'hFF, 8'd255);
		send_header(8'h81, 8'd253);
		send_param(8'h00);
		send_param(8'hFF);
		send_header(8'h7E, 8'd3);
		send_param(8'h12);
		send_param(8'h34);
		send_param(8'h56);
		drain_frames();
	endtask

	task automatic test_mode_switch();
		send_header(8'h42, 8'd2);
		send_param(8'hAA);
		drain_frames();
		set_scramble(1'b0);
		send_param(8'h55);
		send_header(8'h24, 8'd2);
		send_param(8'h01);
		drain_frames();
		set_scramble(1'b1);
		send_param(8'h02);
		send_param(8'hC3);
		drain_frames();
	endtask

	task automatic test_random_frames(input int sidle, input int ridle, input bit mode,
		input int budget);
		int start;
		int pick;
		int count;
		int nsend;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		set_scramble(mode);
		start = effective_items;
		while (effective_items - start < budget) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				drain_frames();
				if ($urandom_range(1) == 1) begin
					set_scramble(!scr_mode);
				end
			end else if (pick < 12) begin
				send_param(8'($urandom));
			end else begin
				pick = $urandom_range(99);
				if (pick < 60) begin
					count = $urandom_range(6);
				end else if (pick < 90) begin
					count = $urandom_range(24, 7);
				end else begin
					count = $urandom_range(255);
				end
				if (count > 24) begin
					nsend = $urandom_range(6);
				end else if ($urandom_range(9) == 0) begin
					nsend = $urandom_range(count);
				end else begin
					nsend = count;
				end
				send_header(8'($urandom), 8'(count));
				repeat (nsend) send_param(8'($urandom));
			end
		end
		drain_frames();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_bus.valid = 1'b0;
		in_bus.is_header = 1'b0;
		in_bus.cmd_code = '0;
		in_bus.param_count = '0;
		in_bus.param_byte = '0;
		out_bus.ready = 1'b0;
		scr_mode = 1'b0;
		key_idx = '0;
		csum = '0;
		params_left = '0;
		send_idle_pct = 14;
		recv_idle_pct = 73;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_plain_frames();
		test_scrambled_frames();
		test_mode_switch();
		test_random_frames(14, 73, 1'b1, 100);
		test_random_frames(73, 14, 1'b0, 100);
		test_random_frames(0, 0, 1'b1, 100);

		$display("Run covered %0d items (%0d headers) in plain, scrambled and mixed frames,",
			effective_items, header_items);
		$display("with %0d frame bytes and %0d closed frames checked, %0d mismatches.",
			checked_bytes, closed_frames, errors);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
